/* rtl/ring_weighted_residual_loglik_defines.svh */
// Assertion macros shared by the ring weighted residual log likelihood RTL.
// RWRL_ASSERT needs clk_i and the active low reset rst_ni in scope; RWRL_ASSERT_RST needs clk_i.
`ifndef RING_WEIGHTED_RESIDUAL_LOGLIK_DEFINES_SVH
`define RING_WEIGHTED_RESIDUAL_LOGLIK_DEFINES_SVH
`ifndef SYNTHESIS
`define RWRL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rwrl assertion failed");
`define RWRL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rwrl reset assertion failed");
`else
`define RWRL_ASSERT(lbl, prop)
`define RWRL_ASSERT_RST(lbl, prop)
`endif
`endif

/* rtl/rwrl_pkg.sv */
// Package of the ring weighted residual log likelihood block.
// Holds beat layout, register indexes and the controller to datapath types.
`timescale 1ns / 1ps
`default_nettype none
package rwrl_pkg;
  localparam int unsigned RWRL_MAX_RINGS = 256;

  localparam int unsigned IN_TDATA_W  = 176;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam int unsigned RIDX_LSB  = 0;
  localparam int unsigned SIGMA_LSB = 8;
  localparam int unsigned COL_LSB   = 40;
  localparam int unsigned ROW_LSB   = 49;
  localparam int unsigned DRE_LSB   = 58;
  localparam int unsigned DIM_LSB   = 82;
  localparam int unsigned RRE_LSB   = 106;
  localparam int unsigned RIM_LSB   = 130;
  localparam int unsigned CTF_LSB   = 154;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic CFG_LOW_CUTOFF = 1'b0;
  localparam logic CFG_MAX_RADIUS = 1'b1;

  localparam int unsigned SQRT_BITS = 9;
  localparam int unsigned DIV_BITS  = 68;
  localparam int unsigned CNT_W     = 7;

  typedef struct packed {
    logic       capture;
    logic       sqrt_step;
    logic [3:0] bit_idx;
    logic       ring_done;
    logic       square;
    logic       div_init;
    logic       div_step;
    logic       term;
    logic       finish;
  } rwrl_cmd_t;

  typedef struct packed {
    logic ring_ok;
    logic last;
    logic out_busy;
  } rwrl_sts_t;
endpackage
`default_nettype wire

/* rtl/rwrl_ctrl.sv */
// Controller state machine of the ring weighted residual log likelihood block.
// Depends on rwrl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ring_weighted_residual_loglik_defines.svh"
module rwrl_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_tvalid_i,
  input  wire logic                action_i,
  output logic                     s_tready_o,
  input  wire rwrl_pkg::rwrl_sts_t sts_i,
  output rwrl_pkg::rwrl_cmd_t      cmd_o
);
  import rwrl_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RING = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_SQR  = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_ACC  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } rwrl_state_e;

  rwrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              capture;

  assign s_tready_o = (state_q == S_IDLE);
  assign capture    = s_tvalid_i & s_tready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.bit_idx = cnt_q[3:0];
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = capture;
        if (capture && action_i == ACT_PIXEL) begin
          state_d = S_RING;
          cnt_d   = CNT_W'(SQRT_BITS - 1);
        end
      end
      S_RING: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.ring_done = 1'b1;
        state_d = S_SQR;
      end
      S_SQR: begin
        cmd_o.square = 1'b1;
        state_d = S_SUM;
      end
      S_SUM: begin
        cmd_o.div_init = 1'b1;
        if (sts_i.ring_ok) begin
          state_d = S_DIV;
          cnt_d   = CNT_W'(DIV_BITS - 1);
        end else begin
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_ACC;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_ACC: begin
        cmd_o.term = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!(sts_i.last && sts_i.out_busy)) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `RWRL_ASSERT(a_pixel_starts_ring, (capture && action_i) |=> (state_q == S_RING))
  `RWRL_ASSERT(a_div_count_range, (state_q == S_DIV) |-> (cnt_q <= CNT_W'(DIV_BITS - 1)))
  `RWRL_ASSERT_RST(a_idle_in_reset, !rst_ni |=> (state_q == S_IDLE))
endmodule
`default_nettype wire

/* rtl/rwrl_dp.sv */
// Datapath of the ring weighted residual log likelihood block: sigma memory,
// ring search, residual power, bit serial divider and saturating sum.
// Depends on rwrl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ring_weighted_residual_loglik_defines.svh"
module rwrl_dp #(
  parameter int unsigned MAX_RINGS = rwrl_pkg::RWRL_MAX_RINGS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [8:0]                          cfg_data_i,
  input  wire logic [rwrl_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  input  wire logic                                in_tuser_i,
  input  wire logic                                in_tlast_i,
  input  wire rwrl_pkg::rwrl_cmd_t                 cmd_i,
  output rwrl_pkg::rwrl_sts_t                      sts_o,
  output logic                                     m_tvalid_o,
  input  wire logic                                m_tready_i,
  output logic [rwrl_pkg::OUT_TDATA_W-1:0]         m_tdata_o
);
  import rwrl_pkg::*;

  localparam int unsigned AW = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;

  logic [31:0] sigma_mem [MAX_RINGS];

  logic [7:0]  low_q;
  logic [8:0]  max_q;

  logic [7:0]         in_ridx;
  logic [31:0]        in_sigma;
  logic signed [8:0]  in_col, in_row;
  logic signed [17:0] col2, row2;
  logic [31:0]        ridx_ext;

  logic [17:0]        s_q;
  logic [8:0]         v_q;
  logic signed [23:0] d_re_q, d_im_q, r_re_q, r_im_q;
  logic signed [15:0] ctf_q;
  logic               last_q;
  logic               ring_ok_q;
  logic [31:0]        sig_q;
  logic signed [40:0] p_re_q, p_im_q;
  logic [51:0]        sq_re_q, sq_im_q;
  logic [31:0]        rem_q, dsor_q;
  logic [67:0]        dq_q;
  logic [62:0]        term_q;
  logic signed [63:0] sum_q;
  logic               out_valid_q;
  logic [63:0]        out_data_q;

  logic [8:0]         sq_try;
  logic [18:0]        sq_lhs;
  logic [9:0]         ring;
  logic [31:0]        ring_ext;
  logic               ring_ok;
  logic signed [26:0] e_re, e_im;
  logic signed [53:0] esq_re, esq_im;
  logic [51:0]        e2;
  logic [32:0]        trial;
  logic               ge;
  logic [68:0]        qp1;
  logic [67:0]        half;
  logic signed [64:0] diff;
  logic signed [63:0] sum_next;

  assign in_ridx  = in_tdata_i[RIDX_LSB +: 8];
  assign in_sigma = in_tdata_i[SIGMA_LSB +: 32];
  assign in_col   = in_tdata_i[COL_LSB +: 9];
  assign in_row   = in_tdata_i[ROW_LSB +: 9];
  assign col2     = 18'(in_col) * 18'(in_col);
  assign row2     = 18'(in_row) * 18'(in_row);
  assign ridx_ext = 32'(in_ridx);

  assign sq_try = v_q | (9'd1 << cmd_i.bit_idx);
  assign sq_lhs = 19'(sq_try) * 19'(sq_try) + 19'(sq_try);

  assign ring     = (s_q == '0) ? 10'd0 : 10'(v_q) + 10'd1;
  assign ring_ext = 32'(ring);
  assign ring_ok  = (32'(low_q) < ring_ext) && (ring_ext < 32'(max_q)) &&
                    (ring_ext < MAX_RINGS);

  assign e_re   = 27'(d_re_q) - p_re_q[40:14];
  assign e_im   = 27'(d_im_q) - p_im_q[40:14];
  assign esq_re = 54'(e_re) * 54'(e_re);
  assign esq_im = 54'(e_im) * 54'(e_im);
  assign e2     = sq_re_q + sq_im_q;

  assign trial = {rem_q, dq_q[67]};
  assign ge    = (trial >= {1'b0, dsor_q});

  assign qp1  = 69'(dq_q) + 69'd1;
  assign half = qp1[68:1];

  assign diff = 65'(sum_q) - 65'(signed'({1'b0, term_q}));

  always_comb begin
    sum_next = sum_q;
    if (ring_ok_q) begin
      if (diff[64] != diff[63]) begin
        sum_next = {1'b1, 63'd0};
      end else begin
        sum_next = diff[63:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_tuser_i == ACT_LOAD && ridx_ext < MAX_RINGS) begin
      sigma_mem[ridx_ext[AW-1:0]] <= in_sigma;
    end
    if (cmd_i.ring_done) begin
      sig_q <= sigma_mem[ring_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q    <= 18'(col2[16:0]) + 18'(row2[16:0]);
      v_q    <= '0;
      d_re_q <= in_tdata_i[DRE_LSB +: 24];
      d_im_q <= in_tdata_i[DIM_LSB +: 24];
      r_re_q <= in_tdata_i[RRE_LSB +: 24];
      r_im_q <= in_tdata_i[RIM_LSB +: 24];
      ctf_q  <= in_tdata_i[CTF_LSB +: 16];
      last_q <= in_tlast_i;
    end
    if (cmd_i.sqrt_step && (sq_lhs < 19'(s_q))) begin
      v_q <= sq_try;
    end
    if (cmd_i.ring_done) begin
      ring_ok_q <= ring_ok;
      p_re_q    <= 41'(ctf_q) * 41'(r_re_q) + 41'sd8192;
      p_im_q    <= 41'(ctf_q) * 41'(r_im_q) + 41'sd8192;
    end
    if (cmd_i.square) begin
      sq_re_q <= esq_re[51:0];
      sq_im_q <= esq_im[51:0];
    end
    if (cmd_i.div_init) begin
      dq_q   <= {e2, 16'd0};
      rem_q  <= '0;
      dsor_q <= (sig_q == '0) ? 32'd1 : sig_q;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(trial - {1'b0, dsor_q}) : trial[31:0];
      dq_q  <= {dq_q[66:0], ge};
    end
    if (cmd_i.term) begin
      term_q <= (|half[67:63]) ? {63{1'b1}} : half[62:0];
    end
    if (cmd_i.finish && last_q) begin
      out_data_q <= sum_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q       <= 8'd0;
      max_q       <= 9'd256;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LOW_CUTOFF: low_q <= cfg_data_i[7:0];
          CFG_MAX_RADIUS: max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        sum_q <= last_q ? 64'sd0 : sum_next;
      end
      if (cmd_i.finish && last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.ring_ok  = ring_ok_q;
  assign sts_o.last     = last_q;
  assign sts_o.out_busy = out_valid_q & ~m_tready_i;
  assign m_tvalid_o     = out_valid_q;
  assign m_tdata_o      = out_data_q;

  `RWRL_ASSERT(a_emit_clears_sum, (cmd_i.finish && last_q) |=> (sum_q == '0 && out_valid_q))
  `RWRL_ASSERT(a_divisor_nonzero, cmd_i.div_step |-> (dsor_q != '0))
endmodule
`default_nettype wire

/* rtl/ring_weighted_residual_loglik.sv */
// Flow: a load beat is taken while idle; an in-range pixel runs 9 ring search steps,
// the ring, square and sum steps, 68 divider steps, the term step and a finish step;
// an excluded pixel skips the divider and term steps; the next beat is taken once idle.
// The bit serial divider sets the rate; a last pixel waits while the previous
// sum is still unread. One item is worked on at a time.
// Reset clears the sum and low cutoff and sets max radius to 256; sigma memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ring_weighted_residual_loglik #(
  parameter int unsigned MAX_RINGS = rwrl_pkg::RWRL_MAX_RINGS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [8:0]                      cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // ring_index, sigma_value, col, row, data_re, data_im, ref_re, ref_im,
  // ctf_gain, zero fill.
  input  wire logic [rwrl_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // action.
  input  wire logic                            s_axis_tuser,
  input  wire logic                            s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // log_likelihood.
  output logic [rwrl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import rwrl_pkg::*;

  rwrl_cmd_t cmd;
  rwrl_sts_t sts;

  rwrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rwrl_dp #(
    .MAX_RINGS (MAX_RINGS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_tdata_i (s_axis_tdata),
    .in_tuser_i (s_axis_tuser),
    .in_tlast_i (s_axis_tlast),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );
endmodule
`default_nettype wire
